>>> sv/i2c_slave_register_access_defines.svh
// assertion macros used by the i2c register access engine
`ifndef I2C_SLAVE_REGISTER_ACCESS_DEFINES_SVH
`define I2C_SLAVE_REGISTER_ACCESS_DEFINES_SVH

// same-cycle implication, checked at every rising edge out of reset
`define I2CSRA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked at every rising edge out of reset
`define I2CSRA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/i2csra_pkg.sv
// types and constants of the i2c slave register access block
package i2csra_pkg;

    localparam int BUFFER_BYTES  = 32;
    localparam int WRITE_LENGTH  = 5;
    localparam int WORD_BYTES    = 4;
    localparam int COUNT_W       = $clog2(BUFFER_BYTES + 1);
    localparam logic [7:0] OVERFLOW_BYTE = 8'hFF;

    typedef enum logic [2:0] {
        ACT_START_READ  = 3'd0,
        ACT_START_WRITE = 3'd1,
        ACT_STOP        = 3'd2,
        ACT_RX          = 3'd3,
        ACT_TX          = 3'd4
    } t_action;

    typedef struct packed {
        logic [2:0]  action;
        logic [7:0]  rx_data;
        logic [31:0] register_contents;
    } t_item;

    typedef struct packed {
        logic [7:0]  tx_data;
        logic        write_strobe;
        logic [31:0] write_word;
        logic        read_strobe;
        logic [7:0]  reg_address;
    } t_result;

endpackage

>>> sv/i2csra_engine.sv
// transaction state and per-event result logic
`include "i2c_slave_register_access_defines.svh"

module i2csra_engine (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_fire,
    input  i2csra_pkg::t_item  i_item,
    output i2csra_pkg::t_result o_result
);
    import i2csra_pkg::*;

    logic [COUNT_W-1:0] r_received_count, n_received_count;
    logic [COUNT_W-1:0] r_sent_count, n_sent_count;
    logic [7:0]         r_address_byte, n_address_byte;
    logic [31:0]        r_incoming_word, n_incoming_word;
    logic [31:0]        r_outgoing_word, n_outgoing_word;
    logic               r_read_direction, n_read_direction;

    logic [1:0]         rx_lane;
    logic [1:0]         tx_lane;
    logic               fetch;
    logic [31:0]        send_word;

    assign rx_lane   = 2'(r_received_count - COUNT_W'(1));
    assign tx_lane   = r_sent_count[1:0];
    assign fetch     = r_read_direction && (r_sent_count == '0)
                       && (r_received_count == COUNT_W'(1));
    assign send_word = fetch ? i_item.register_contents : r_outgoing_word;

    always_comb begin
        n_received_count = r_received_count;
        n_sent_count     = r_sent_count;
        n_address_byte   = r_address_byte;
        n_incoming_word  = r_incoming_word;
        n_outgoing_word  = r_outgoing_word;
        n_read_direction = r_read_direction;
        o_result              = '0;
        o_result.reg_address  = r_address_byte;
        unique case (t_action'(i_item.action))
            ACT_START_READ: begin
                n_read_direction = 1'b1;
            end
            ACT_START_WRITE: begin
                n_read_direction = 1'b0;
            end
            ACT_STOP: begin
                if (r_received_count == COUNT_W'(WRITE_LENGTH)) begin
                    o_result.write_strobe = 1'b1;
                    o_result.write_word   = r_incoming_word;
                end
                n_received_count = '0;
                n_sent_count     = '0;
                n_address_byte   = '0;
                n_incoming_word  = '0;
                n_outgoing_word  = '0;
            end
            ACT_RX: begin
                if (r_received_count < COUNT_W'(BUFFER_BYTES)) begin
                    if (r_received_count == '0) begin
                        n_address_byte = i_item.rx_data;
                    end else if (r_received_count < COUNT_W'(WRITE_LENGTH)) begin
                        for (int b = 0; b < WORD_BYTES; b++) begin
                            if (rx_lane == 2'(b)) begin
                                n_incoming_word[b*8 +: 8] = i_item.rx_data;
                            end
                        end
                    end
                    n_received_count = r_received_count + COUNT_W'(1);
                end
            end
            ACT_TX: begin
                if (fetch) begin
                    n_outgoing_word      = i_item.register_contents;
                    o_result.read_strobe = 1'b1;
                end
                if (r_sent_count < COUNT_W'(BUFFER_BYTES)) begin
                    if (r_sent_count < COUNT_W'(WORD_BYTES)) begin
                        o_result.tx_data = send_word[{tx_lane, 3'b000} +: 8];
                    end
                    n_sent_count = r_sent_count + COUNT_W'(1);
                end else begin
                    o_result.tx_data = OVERFLOW_BYTE;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_received_count <= '0;
            r_sent_count     <= '0;
            r_address_byte   <= '0;
            r_incoming_word  <= '0;
            r_outgoing_word  <= '0;
            r_read_direction <= 1'b0;
        end else if (i_fire) begin
            r_received_count <= n_received_count;
            r_sent_count     <= n_sent_count;
            r_address_byte   <= n_address_byte;
            r_incoming_word  <= n_incoming_word;
            r_outgoing_word  <= n_outgoing_word;
            r_read_direction <= n_read_direction;
        end
    end

    `I2CSRA_ASSERT_NOW(a_rcnt_bound, i_clk, i_rst_n, 1'b1,
        r_received_count <= COUNT_W'(BUFFER_BYTES), "receive count past buffer size")
    `I2CSRA_ASSERT_NOW(a_scnt_bound, i_clk, i_rst_n, 1'b1,
        r_sent_count <= COUNT_W'(BUFFER_BYTES), "send count past buffer size")
    `I2CSRA_ASSERT_NOW(a_wstrobe_stop, i_clk, i_rst_n, i_fire && o_result.write_strobe,
        t_action'(i_item.action) == ACT_STOP, "write commit outside stop")
    `I2CSRA_ASSERT_NOW(a_rstrobe_first, i_clk, i_rst_n, i_fire && o_result.read_strobe,
        r_sent_count == '0 && r_received_count == COUNT_W'(1), "fetch not on first send")
    `I2CSRA_ASSERT_NEXT(a_stop_clears, i_clk, i_rst_n,
        i_fire && t_action'(i_item.action) == ACT_STOP,
        r_received_count == '0 && r_sent_count == '0 && r_address_byte == '0,
        "stop left transaction state")

endmodule

>>> sv/i2c_slave_register_access.sv
// Transaction layer of an i2c slave with 32-bit registers. Each input transfer is one bus
// event (start read, start write, stop, byte received, byte to send) and gives exactly one
// output transfer. An event is captured in an input register, evaluated against the
// transaction counters combinationally and lands in the output register, where the result
// is presented until it is taken; one event is taken every cycle while the output side
// keeps up, and while a finished result waits the input register takes one more event and
// then stalls.
// register_contents must hold the register named by the first received byte of the
// transaction when a send is requested.
module i2c_slave_register_access (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [2:0]  i_action,
    input  logic [7:0]  i_rx_data,
    input  logic [31:0] i_register_contents,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_tx_data,
    output logic        o_write_strobe,
    output logic [31:0] o_write_word,
    output logic        o_read_strobe,
    output logic [7:0]  o_reg_address
);
    import i2csra_pkg::*;

    logic    r_in_valid;
    t_item   r_in;
    logic    r_out_valid;
    t_result r_out;
    t_result result;
    logic    advance;

    assign advance = r_in_valid && (!r_out_valid || !i_stall);
    assign o_stall = r_in_valid && !advance;

    i2csra_engine u_engine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (advance),
        .i_item   (r_in),
        .o_result (result)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_in.action            <= i_action;
            r_in.rx_data           <= i_rx_data;
            r_in.register_contents <= i_register_contents;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= result;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_tx_data      = r_out.tx_data;
    assign o_write_strobe = r_out.write_strobe;
    assign o_write_word   = r_out.write_word;
    assign o_read_strobe  = r_out.read_strobe;
    assign o_reg_address  = r_out.reg_address;

endmodule

>>> tb/tb_i2c_slave_register_access.sv
// testbench for the i2c slave register access block: scoreboard, stimulus tasks and checks
`timescale 1ns / 100ps

module tb_i2c_slave_register_access;
    import i2csra_pkg::*;

    class i2c_txn_scoreboard;
        logic [COUNT_W-1:0] rx_count = '0;
        logic [COUNT_W-1:0] tx_count = '0;
        logic [7:0]  addr_byte = '0;
        logic [31:0] rx_word = '0;
        logic [31:0] tx_word = '0;
        bit          read_dir = 1'b0;
        logic [31:0] host_regs [256];
        t_result     pending [$];
        int errors = 0;
        int results_checked = 0;
        int commits = 0;
        int fetches = 0;
        int rx_dropped = 0;
        int tx_overflows = 0;

        function void seed_registers();
            foreach (host_regs[i]) host_regs[i] = $urandom;
        endfunction

        function logic [31:0] addressed_register();
            return host_regs[addr_byte];
        endfunction

        function void note_event(logic [2:0] act, logic [7:0] rx, logic [31:0] contents);
            t_result r;
            r = '0;
            r.reg_address = addr_byte;
            case (act)
                ACT_START_READ: begin
                    read_dir = 1'b1;
                end
                ACT_START_WRITE: begin
                    read_dir = 1'b0;
                end
                ACT_STOP: begin
                    if (rx_count == WRITE_LENGTH) begin
                        r.write_strobe = 1'b1;
                        r.write_word = rx_word;
                        host_regs[addr_byte] = rx_word;
                        commits++;
                    end
                    rx_count = '0;
                    tx_count = '0;
                    addr_byte = '0;
                    rx_word = '0;
                    tx_word = '0;
                end
                ACT_RX: begin
                    if (rx_count < BUFFER_BYTES) begin
                        if (rx_count == 0)
                            addr_byte = rx;
                        else if (rx_count < WRITE_LENGTH)
                            rx_word[(int'(rx_count) - 1) * 8 +: 8] = rx;
                        rx_count++;
                    end else begin
                        rx_dropped++;
                    end
                end
                ACT_TX: begin
                    if (read_dir && tx_count == 0 && rx_count == 1) begin
                        tx_word = contents;
                        r.read_strobe = 1'b1;
                        fetches++;
                    end
                    if (tx_count < BUFFER_BYTES) begin
                        if (tx_count < WORD_BYTES)
                            r.tx_data = tx_word[int'(tx_count) * 8 +: 8];
                        tx_count++;
                    end else begin
                        r.tx_data = OVERFLOW_BYTE;
                        tx_overflows++;
                    end
                end
                default: ;
            endcase
            pending.push_back(r);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                errors++;
                $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
            end
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (pending.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, got 0x%0h", $time, got);
                return;
            end
            want = pending.pop_front();
            results_checked++;
            compare_field("tx_data", want.tx_data, got.tx_data);
            compare_field("write_strobe", want.write_strobe, got.write_strobe);
            compare_field("write_word", want.write_word, got.write_word);
            compare_field("read_strobe", want.read_strobe, got.read_strobe);
            compare_field("reg_address", want.reg_address, got.reg_address);
        endfunction
    endclass

    localparam logic [2:0] ACT_UNUSED = 3'd7;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TAIL_CYCLES = 10;
    localparam int PHASE_EVENTS = 420;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [2:0]  i_action;
    logic [7:0]  i_rx_data;
    logic [31:0] i_register_contents;
    logic        o_valid;
    logic        i_stall;
    logic [7:0]  o_tx_data;
    logic        o_write_strobe;
    logic [31:0] o_write_word;
    logic        o_read_strobe;
    logic [7:0]  o_reg_address;

    i2c_txn_scoreboard sb = new();

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int events_sent = 0;
    int idle_cycles = 0;

    i2c_slave_register_access u_top (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_valid),
        .o_stall             (o_stall),
        .i_action            (i_action),
        .i_rx_data           (i_rx_data),
        .i_register_contents (i_register_contents),
        .o_valid             (o_valid),
        .i_stall             (i_stall),
        .o_tx_data           (o_tx_data),
        .o_write_strobe      (o_write_strobe),
        .o_write_word        (o_write_word),
        .o_read_strobe       (o_read_strobe),
        .o_reg_address       (o_reg_address)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // result side: random stall, check every transfer
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            sb.check_result({o_tx_data, o_write_strobe, o_write_word, o_read_strobe,
                             o_reg_address});
        i_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("i2c_slave_register_access regression: fail");
            $finish;
        end
    end

    task automatic send_event(input logic [2:0] act, input logic [7:0] rx);
        logic [31:0] contents;
        contents = (act == ACT_TX) ? sb.addressed_register() : 32'($urandom);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_action <= act;
        i_rx_data <= rx;
        i_register_contents <= contents;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sb.note_event(act, rx, contents);
        if (act <= ACT_TX)
            events_sent++;
    endtask

    function automatic logic [7:0] pick_address();
        return $urandom_range(1) ? 8'($urandom_range(7)) : 8'($urandom_range(255));
    endfunction

    task automatic write_txn(input logic [7:0] addr, input logic [31:0] word, input bit broken);
        int n_data;
        n_data = broken ? $urandom_range(7) : WORD_BYTES;
        send_event(ACT_START_WRITE, 8'($urandom));
        send_event(ACT_RX, addr);
        for (int i = 0; i < n_data; i++)
            send_event(ACT_RX, (i < WORD_BYTES) ? word[i * 8 +: 8] : 8'($urandom));
        send_event(ACT_STOP, 8'($urandom));
    endtask

    task automatic read_txn(input logic [7:0] addr, input int n_tx, input bit broken);
        int n_addr;
        n_addr = broken ? $urandom_range(2) : 1;
        send_event(ACT_START_WRITE, 8'($urandom));
        repeat (n_addr) send_event(ACT_RX, addr);
        send_event((broken && $urandom_range(1)) ? ACT_START_WRITE : ACT_START_READ,
                   8'($urandom));
        repeat (n_tx) send_event(ACT_TX, 8'($urandom));
        send_event(ACT_STOP, 8'($urandom));
    endtask

    // long transfers can run the receive and send counters into saturation at the buffer size
    task automatic overflow_txn();
        send_event(ACT_START_WRITE, 8'($urandom));
        repeat ($urandom_range(1) ? 1 : $urandom_range(28, 40))
            send_event(ACT_RX, 8'($urandom));
        send_event(ACT_START_READ, 8'($urandom));
        repeat ($urandom_range(28, 40)) send_event(ACT_TX, 8'($urandom));
        send_event(ACT_STOP, 8'($urandom));
    endtask

    task automatic run_phase(input int send_pct, input int recv_pct, input int n_events);
        int target;
        int pick;
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
        target = events_sent + n_events;
        while (events_sent < target) begin
            pick = $urandom_range(99);
            if (pick < 35)
                write_txn(pick_address(), $urandom, $urandom_range(99) < 15);
            else if (pick < 70)
                read_txn(pick_address(), $urandom_range(1, 6), $urandom_range(99) < 15);
            else if (pick < 76)
                overflow_txn();
            else
                repeat ($urandom_range(1, 6))
                    send_event(3'($urandom_range(7)), 8'($urandom));
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_stall = 1'b0;
        i_action = ACT_STOP;
        i_rx_data = '0;
        i_register_contents = '0;
        sb.seed_registers();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extreme bytes, fetch and read past the word, send without fetch
        write_txn(8'hFF, 32'hFFFF_FFFF, 1'b0);
        write_txn(8'h00, 32'h0000_0000, 1'b0);
        read_txn(8'hFF, 5, 1'b0);
        send_event(ACT_TX, 8'h00);
        send_event(ACT_UNUSED, 8'hFF);
        send_event(ACT_STOP, 8'h00);

        run_phase(37, 59, PHASE_EVENTS);
        run_phase(59, 37, PHASE_EVENTS);
        run_phase(0, 0, PHASE_EVENTS);

        i_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("%0d bus events driven, %0d results checked, %0d register writes, %0d fetches",
                 events_sent, sb.results_checked, sb.commits, sb.fetches);
        $display("%0d received bytes dropped at the buffer limit, %0d send overflow bytes",
                 sb.rx_dropped, sb.tx_overflows);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("i2c_slave_register_access regression: pass");
        else
            $display("i2c_slave_register_access regression: fail");
        $finish;
    end

endmodule

>>> i2c_slave_register_access.f
+incdir+sv
sv/i2csra_pkg.sv
sv/i2csra_engine.sv
sv/i2c_slave_register_access.sv
tb/tb_i2c_slave_register_access.sv
